### design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/spq_pkg.sv
// shared types and constants of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CMD_W    = 2;
  localparam int AGE_W    = 8;
  localparam int ITEMS_W  = 10;
  localparam int NUMBER_W = 16;
  localparam int RIDX_W   = 4;
  localparam int OCC_W    = 5;
  localparam int TOTAL_W  = 14;

  localparam logic [OCC_W-1:0]   OCC_MAX   = 5'd31;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'd16383;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [AGE_W-1:0]    age;
    logic [ITEMS_W-1:0]  items;
    logic [NUMBER_W-1:0] number;
  } entry_t;

  typedef struct packed {
    cmd_t              command;
    entry_t            entry;
    logic [RIDX_W-1:0] read_index;
  } request_t;

  typedef struct packed {
    entry_t             front;
    entry_t             rd;
    logic [OCC_W-1:0]   occupancy;
    logic [TOTAL_W-1:0] items_total;
    logic               is_empty;
    logic               overflow;
  } result_t;

endpackage

### design/spq_in_if.sv
// command channel interface of the sorted priority queue
`timescale 1ns / 1ps

interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::CMD_W-1:0]     command;
  logic [spq_pkg::AGE_W-1:0]     entry_age;
  logic [spq_pkg::ITEMS_W-1:0]   entry_items;
  logic [spq_pkg::NUMBER_W-1:0]  entry_number;
  logic [spq_pkg::RIDX_W-1:0]    read_index;

  modport source (
    output valid, command, entry_age, entry_items, entry_number, read_index,
    input  ready
  );

  modport sink (
    input  valid, command, entry_age, entry_items, entry_number, read_index,
    output ready
  );
endinterface

### design/spq_out_if.sv
// result channel interface of the sorted priority queue
`timescale 1ns / 1ps

interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::AGE_W-1:0]     front_age;
  logic [spq_pkg::ITEMS_W-1:0]   front_items;
  logic [spq_pkg::NUMBER_W-1:0]  front_number;
  logic [spq_pkg::AGE_W-1:0]     read_age;
  logic [spq_pkg::ITEMS_W-1:0]   read_items;
  logic [spq_pkg::NUMBER_W-1:0]  read_number;
  logic [spq_pkg::OCC_W-1:0]     occupancy;
  logic [spq_pkg::TOTAL_W-1:0]   items_total;
  logic                          is_empty;
  logic                          overflow;

  modport source (
    output valid, front_age, front_items, front_number, read_age, read_items,
           read_number, occupancy, items_total, is_empty, overflow,
    input  ready
  );

  modport sink (
    input  valid, front_age, front_items, front_number, read_age, read_items,
           read_number, occupancy, items_total, is_empty, overflow,
    output ready
  );
endinterface

### design/spq_ram.sv
// entry store: one write port, one registered read port
`timescale 1ns / 1ps

module spq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  spq_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output spq_pkg::entry_t  rdata
);

  spq_pkg::entry_t mem [DEPTH];
  spq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/spq_seq.sv
// sequencer: walks the store one entry at a time with a shared key compare
`timescale 1ns / 1ps

module spq_seq #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CW          = 5,
  parameter int AW          = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  spq_pkg::request_t  req,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ready,
  output spq_pkg::result_t   result,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output spq_pkg::entry_t    ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  spq_pkg::entry_t    ram_rdata
);

  localparam int SW = spq_pkg::ITEMS_W + CW;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_ENQ_RD  = 10'b00_0000_0010,
    S_ENQ_CMP = 10'b00_0000_0100,
    S_ENQ_WR  = 10'b00_0000_1000,
    S_DEQ_RD  = 10'b00_0001_0000,
    S_DEQ_WR  = 10'b00_0010_0000,
    S_IDX_RD  = 10'b00_0100_0000,
    S_IDX_CAP = 10'b00_1000_0000,
    S_FRT_RD  = 10'b01_0000_0000,
    S_FRT_CAP = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic              done_r, done_nxt;
  spq_pkg::request_t req_r, req_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic              ovf_r, ovf_nxt;
  spq_pkg::entry_t   rd_r, rd_nxt;
  spq_pkg::entry_t   front_r, front_nxt;

  logic [CW-1:0]     idx_dec;
  logic              age_gt;
  logic              ridx_ok;

  logic [CW+spq_pkg::OCC_W-1:0]   cnt_ext;
  logic [SW+spq_pkg::TOTAL_W-1:0] sum_ext;

  assign idx_dec = idx_r - ONE_C;
  assign age_gt  = ram_rdata.age > req_r.entry.age;
  assign ridx_ok = {{CW{1'b0}}, req.read_index} < {{spq_pkg::RIDX_W{1'b0}}, count_r};

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    ovf_nxt   = ovf_r;
    rd_nxt    = rd_r;
    front_nxt = front_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = req_r.entry;
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (done_r) begin
          if (res_ready) begin
            done_nxt = 1'b0;
          end
        end else if (start) begin
          req_nxt = req;
          ovf_nxt = 1'b0;
          rd_nxt  = '0;
          unique case (req.command)
            spq_pkg::CMD_ENQ: begin
              if (count_r == DEPTH_C) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_FRT_RD;
              end else begin
                idx_nxt   = count_r;
                state_nxt = (count_r == '0) ? S_ENQ_WR : S_ENQ_RD;
              end
            end
            spq_pkg::CMD_DEQ: begin
              if (count_r == '0) begin
                state_nxt = S_FRT_RD;
              end else begin
                sum_nxt = sum_r - SW'(front_r.items);
                idx_nxt = ONE_C;
                if (count_r == ONE_C) begin
                  count_nxt = '0;
                  state_nxt = S_FRT_RD;
                end else begin
                  state_nxt = S_DEQ_RD;
                end
              end
            end
            spq_pkg::CMD_READ: begin
              if (ridx_ok) begin
                idx_nxt   = CW'(req.read_index);
                state_nxt = S_IDX_RD;
              end else begin
                state_nxt = S_FRT_RD;
              end
            end
            default: begin
              state_nxt = S_FRT_RD;
            end
          endcase
        end
      end
      S_ENQ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_dec[AW-1:0];
        state_nxt = S_ENQ_CMP;
      end
      S_ENQ_CMP: begin
        if (age_gt) begin
          state_nxt = S_ENQ_WR;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          idx_nxt   = idx_dec;
          state_nxt = (idx_dec == '0) ? S_ENQ_WR : S_ENQ_RD;
        end
      end
      S_ENQ_WR: begin
        ram_we    = 1'b1;
        count_nxt = count_r + ONE_C;
        sum_nxt   = sum_r + SW'(req_r.entry.items);
        state_nxt = S_FRT_RD;
      end
      S_DEQ_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_DEQ_WR;
      end
      S_DEQ_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_dec[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + ONE_C;
        if (idx_r + ONE_C == count_r) begin
          count_nxt = count_r - ONE_C;
          state_nxt = S_FRT_RD;
        end else begin
          state_nxt = S_DEQ_RD;
        end
      end
      S_IDX_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_IDX_CAP;
      end
      S_IDX_CAP: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_FRT_RD;
      end
      S_FRT_RD: begin
        if (count_r == '0) begin
          front_nxt = '0;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_nxt = S_FRT_CAP;
        end
      end
      S_FRT_CAP: begin
        front_nxt = ram_rdata;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    ovf_r   <= ovf_nxt;
    rd_r    <= rd_nxt;
    front_r <= front_nxt;
  end

  assign idle      = (state_r == S_IDLE) && !done_r;
  assign res_valid = done_r;

  // saturate the status counts to the result field widths
  assign cnt_ext = {{spq_pkg::OCC_W{1'b0}}, count_r};
  assign sum_ext = {{spq_pkg::TOTAL_W{1'b0}}, sum_r};

  always_comb begin
    result.front    = front_r;
    result.rd       = rd_r;
    result.overflow = ovf_r;
    result.is_empty = (count_r == '0);
    if (cnt_ext > (CW + spq_pkg::OCC_W)'(spq_pkg::OCC_MAX)) begin
      result.occupancy = spq_pkg::OCC_MAX;
    end else begin
      result.occupancy = cnt_ext[spq_pkg::OCC_W-1:0];
    end
    if (sum_ext > (SW + spq_pkg::TOTAL_W)'(spq_pkg::TOTAL_MAX)) begin
      result.items_total = spq_pkg::TOTAL_MAX;
    end else begin
      result.items_total = sum_ext[spq_pkg::TOTAL_W-1:0];
    end
  end

endmodule

### design/sorted_priority_queue.sv
// top level of the sorted priority queue: sequencer, entry store, result register
//
//   channel | dir | handshake     | beat contents
//   in_ch   | in  | valid / ready | command, entry key/items/tag, read index
//   out_ch  | out | valid / ready | front entry, read entry, occupancy, total, flags
//
// one command at a time; in_ch.ready is high only while the sequencer is idle
// enqueue: from the tail, each entry keyed not above the new one moves back a slot; full drops it
// dequeue: remaining entries move forward a slot; read: fetches the indexed entry if in range
// each step is one store access with a registered read
// synchronous active-low reset empties the queue; the store itself is not cleared
// a stalled result holds in the output register and the next result waits in the sequencer
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);

  spq_pkg::request_t req;
  spq_pkg::result_t  seq_result;
  spq_pkg::result_t  out_r;
  logic              out_valid_r;
  logic              seq_idle;
  logic              res_valid;
  logic              res_ready;
  logic              start;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  spq_pkg::entry_t   ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  spq_pkg::entry_t   ram_rdata;

  assign req.command      = spq_pkg::cmd_t'(in_ch.command);
  assign req.entry.age    = in_ch.entry_age;
  assign req.entry.items  = in_ch.entry_items;
  assign req.entry.number = in_ch.entry_number;
  assign req.read_index   = in_ch.read_index;

  assign in_ch.ready = seq_idle;
  assign start       = in_ch.valid && seq_idle;
  assign res_ready   = !out_valid_r || out_ch.ready;

  spq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CW          (CW),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (seq_result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= seq_result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.front_age    = out_r.front.age;
  assign out_ch.front_items  = out_r.front.items;
  assign out_ch.front_number = out_r.front.number;
  assign out_ch.read_age     = out_r.rd.age;
  assign out_ch.read_items   = out_r.rd.items;
  assign out_ch.read_number  = out_r.rd.number;
  assign out_ch.occupancy    = out_r.occupancy;
  assign out_ch.items_total  = out_r.items_total;
  assign out_ch.is_empty     = out_r.is_empty;
  assign out_ch.overflow     = out_r.overflow;

endmodule

### design/spq_checker.sv
// port-level checker of the sorted priority queue and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [spq_pkg::OCC_W-1:0]   occupancy,
  input logic                        is_empty,
  input logic                        overflow
);

  localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC =
    spq_pkg::OCC_W'((QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH);

  // one command in flight at a time
  `SPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  `SPQ_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (occupancy == '0), "empty flag mismatch")

  // a dropped enqueue only happens on a full queue
  `SPQ_ASSERT_NOW(a_overflow_full, out_valid && overflow, occupancy == FULL_OCC, "overflow not full")

  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(occupancy), "beat dropped")

endmodule

bind sorted_priority_queue spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .occupancy (out_ch.occupancy),
  .is_empty  (out_ch.is_empty),
  .overflow  (out_ch.overflow)
);

### tb/sorted_priority_queue_tb.sv
// testbench of the sorted priority queue: directed and random command traffic checked against a shadow queue
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;

  class priority_shadow;
    spq_pkg::entry_t  slots[DEPTH];
    int               stored;
    int               total;
    int               mismatches;
    int               checked;
    spq_pkg::result_t expected_status[$];

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function spq_pkg::result_t predict(spq_pkg::request_t req);
      spq_pkg::result_t r;
      int               pos;
      int               i;
      r = '0;
      case (req.command)
        spq_pkg::CMD_ENQ: begin
          if (stored >= DEPTH) begin
            r.overflow = 1'b1;
          end else begin
            pos = 0;
            while (pos < stored && slots[pos].age > req.entry.age) pos++;
            for (i = stored; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = req.entry;
            stored++;
            total += req.entry.items;
          end
        end
        spq_pkg::CMD_DEQ: begin
          if (stored > 0) begin
            total -= slots[0].items;
            for (i = 1; i < stored; i++) slots[i-1] = slots[i];
            stored--;
          end
        end
        spq_pkg::CMD_READ: begin
          if (req.read_index < stored) r.rd = slots[req.read_index];
        end
        default: begin
        end
      endcase
      if (stored > 0) r.front = slots[0];
      r.occupancy   = (stored > int'(spq_pkg::OCC_MAX)) ? spq_pkg::OCC_MAX
                                                       : stored[spq_pkg::OCC_W-1:0];
      r.items_total = (total > int'(spq_pkg::TOTAL_MAX)) ? spq_pkg::TOTAL_MAX
                                                        : total[spq_pkg::TOTAL_W-1:0];
      r.is_empty    = (stored == 0);
      return r;
    endfunction

    task apply_command(spq_pkg::request_t req);
      expected_status.push_back(predict(req));
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("status beat %0d field %s got %0h want %0h", checked, name, got, want));
    endtask

    task compare_status(spq_pkg::result_t got);
      spq_pkg::result_t want;
      if (expected_status.size() == 0) begin
        report($sformatf("status beat %0d arrived with nothing expected", checked));
        checked++;
        return;
      end
      want = expected_status.pop_front();
      check_field("front_age", 32'(got.front.age), 32'(want.front.age));
      check_field("front_items", 32'(got.front.items), 32'(want.front.items));
      check_field("front_number", 32'(got.front.number), 32'(want.front.number));
      check_field("read_age", 32'(got.rd.age), 32'(want.rd.age));
      check_field("read_items", 32'(got.rd.items), 32'(want.rd.items));
      check_field("read_number", 32'(got.rd.number), 32'(want.rd.number));
      check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      check_field("items_total", 32'(got.items_total), 32'(want.items_total));
      check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      check_field("overflow", 32'(got.overflow), 32'(want.overflow));
      checked++;
    endtask

    function int pending();
      return expected_status.size();
    endfunction

    task report_leftover();
      if (expected_status.size() != 0)
        report($sformatf("%0d status beats never arrived", expected_status.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic calm;
  int   quiet_cycles = 0;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  priority_shadow shadow = new();

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin : beat_monitor
    spq_pkg::request_t req;
    spq_pkg::result_t  res;
    logic              in_beat;
    logic              out_beat;
    in_beat  = rst_n && in_ch.valid && in_ch.ready;
    out_beat = rst_n && out_ch.valid && out_ch.ready;
    if (in_beat) begin
      req.command      = spq_pkg::cmd_t'(in_ch.command);
      req.entry.age    = in_ch.entry_age;
      req.entry.items  = in_ch.entry_items;
      req.entry.number = in_ch.entry_number;
      req.read_index   = in_ch.read_index;
      shadow.apply_command(req);
    end
    if (out_beat) begin
      res.front.age    = out_ch.front_age;
      res.front.items  = out_ch.front_items;
      res.front.number = out_ch.front_number;
      res.rd.age       = out_ch.read_age;
      res.rd.items     = out_ch.read_items;
      res.rd.number    = out_ch.read_number;
      res.occupancy    = out_ch.occupancy;
      res.items_total  = out_ch.items_total;
      res.is_empty     = out_ch.is_empty;
      res.overflow     = out_ch.overflow;
      shadow.compare_status(res);
    end
    if (!rst_n || in_beat || out_beat) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // status channel sink with random back-pressure
  initial begin : status_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_command(spq_pkg::cmd_t cmd, logic [spq_pkg::AGE_W-1:0] age,
                              logic [spq_pkg::ITEMS_W-1:0] items,
                              logic [spq_pkg::NUMBER_W-1:0] number,
                              logic [spq_pkg::RIDX_W-1:0] idx);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.entry_age    <= age;
    in_ch.entry_items  <= items;
    in_ch.entry_number <= number;
    in_ch.read_index   <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int                           p;
    int                           n;
    int                           roll;
    int                           enq_w;
    int                           deq_w;
    int                           key_span;
    logic [31:0]                  rnd;
    spq_pkg::cmd_t                cmd;
    logic [spq_pkg::AGE_W-1:0]    age;
    logic [spq_pkg::ITEMS_W-1:0]  items;
    logic [spq_pkg::NUMBER_W-1:0] number;
    logic [spq_pkg::RIDX_W-1:0]   idx;

    rst_n              <= 1'b0;
    calm               <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= spq_pkg::CMD_NOP;
    in_ch.entry_age    <= '0;
    in_ch.entry_items  <= '0;
    in_ch.entry_number <= '0;
    in_ch.read_index   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: reads, dequeue and unused command
    send_command(spq_pkg::CMD_READ, 8'hff, 10'h3ff, 16'hffff, 4'd0);
    send_command(spq_pkg::CMD_READ, 8'h00, 10'h000, 16'h0000, 4'd15);
    send_command(spq_pkg::CMD_DEQ, 8'hff, 10'h3ff, 16'hffff, 4'd15);
    send_command(spq_pkg::CMD_NOP, 8'h5a, 10'h2a5, 16'h1234, 4'd7);
    // key extremes and equal keys, newest first
    send_command(spq_pkg::CMD_ENQ, 8'hff, 10'h3ff, 16'hffff, 4'd15);
    send_command(spq_pkg::CMD_ENQ, 8'h00, 10'h000, 16'h0000, 4'd0);
    send_command(spq_pkg::CMD_ENQ, 8'hff, 10'h001, 16'h0001, 4'd3);
    send_command(spq_pkg::CMD_ENQ, 8'h00, 10'h002, 16'h0002, 4'd9);
    send_command(spq_pkg::CMD_ENQ, 8'h80, 10'h200, 16'h8000, 4'd12);
    for (n = 0; n < 6; n++)
      send_command(spq_pkg::CMD_READ, 8'h00, 10'h000, 16'h0000, n[spq_pkg::RIDX_W-1:0]);
    send_command(spq_pkg::CMD_DEQ, 8'h00, 10'h000, 16'h0000, 4'd0);
    send_command(spq_pkg::CMD_READ, 8'h00, 10'h000, 16'h0000, 4'd0);
    send_command(spq_pkg::CMD_NOP, 8'h00, 10'h000, 16'h0000, 4'd0);
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      case (p % 3)
        0: begin enq_w = 75; deq_w = 10; end
        1: begin enq_w = 20; deq_w = 60; end
        default: begin enq_w = 45; deq_w = 30; end
      endcase
      key_span = ($urandom_range(0, 1) == 1) ? 255 : 3;
      calm <= (p % 4 == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < enq_w) cmd = spq_pkg::CMD_ENQ;
        else if (roll < enq_w + deq_w) cmd = spq_pkg::CMD_DEQ;
        else if (roll < 98) cmd = spq_pkg::CMD_READ;
        else cmd = spq_pkg::CMD_NOP;
        rnd    = $urandom_range(0, key_span);
        age    = rnd[spq_pkg::AGE_W-1:0];
        rnd    = $urandom_range(0, 1023);
        items  = rnd[spq_pkg::ITEMS_W-1:0];
        rnd    = $urandom;
        number = rnd[spq_pkg::NUMBER_W-1:0];
        rnd    = $urandom_range(0, 15);
        idx    = rnd[spq_pkg::RIDX_W-1:0];
        send_command(cmd, age, items, number, idx);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    shadow.report_leftover();
    if (shadow.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/spq_pkg.sv
design/spq_in_if.sv
design/spq_out_if.sv
design/spq_ram.sv
design/spq_seq.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
tb/sorted_priority_queue_tb.sv
